// File: src/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants, codes and helpers for the block padding engine.
// ----------------------------------------------------------------------------
package bpe_pkg;

    // Largest block size and the widths that follow from it
    localparam int MAX_BLOCK = 32;
    localparam int ADDR_W    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int CNT_W     = $clog2(MAX_BLOCK + 1);

    // Field widths fixed by the interface
    localparam int BYTE_W = 8;
    localparam int BS_W   = 6;
    localparam int STAT_W = 2;
    localparam int MODE_W = 2;

    localparam logic [ADDR_W:0]    MAX_RING = (ADDR_W + 1)'(MAX_BLOCK);
    localparam logic [BYTE_W-1:0]  ISO_MARK = 8'h80;

    // Padding schemes
    localparam logic [MODE_W-1:0] MODE_PKCS7 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_X923  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ISO   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_DIR  = 2'd1;
    localparam logic [1:0] REG_BS   = 2'd2;

    // Status codes on the final result
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_BYTES = 2'd1;
    localparam logic [STAT_W-1:0] ST_SHORT     = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_LEN   = 2'd3;

    // Add two window positions modulo the window depth
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MAX_RING) begin
            s = s - MAX_RING;
        end
        return s[ADDR_W-1:0];
    endfunction

    // Clamp the programmed block size into 1..MAX_BLOCK
    function automatic logic [CNT_W-1:0] eff_block(input logic [BS_W-1:0] bs);
        logic [CNT_W-1:0] r;
        if (bs == '0) begin
            r = CNT_W'(1);
        end else if ({1'b0, bs} > (BS_W + 1)'(MAX_BLOCK)) begin
            r = CNT_W'(MAX_BLOCK);
        end else begin
            r = CNT_W'(bs);
        end
        return r;
    endfunction

endpackage

// File: src/bpe_hold_mem.sv
// ----------------------------------------------------------------------------
// bpe_hold_mem
// Hold window storage: one write and one registered read per cycle, with
// write data forwarded when both ports hit the same entry.
// ----------------------------------------------------------------------------
module bpe_hold_mem (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [bpe_pkg::ADDR_W-1:0]        i_wr_addr,
    input  logic [bpe_pkg::BYTE_W-1:0]        i_wr_data,
    input  logic [bpe_pkg::ADDR_W-1:0]        i_rd_addr,
    output logic [bpe_pkg::BYTE_W-1:0]        o_rd_data
);

    logic [bpe_pkg::BYTE_W-1:0] r_mem [bpe_pkg::MAX_BLOCK];
    logic [bpe_pkg::BYTE_W-1:0] r_rd_data;

    // Store the incoming byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read every cycle; forward a same-entry write
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/block_padding_engine_top.sv
// In pad direction a byte is registered and appears on the output in the cycle after its
//   transfer; in unpad direction it waits until block_size newer bytes arrive or the message ends.
// One byte per cycle is taken while a message streams and the output is not stalled; its end adds
//   up to block_size pad bytes, or in unpad direction a scan of the held bytes followed by the
//   kept bytes (or a final result without a byte); no new input is taken until that is done.
// Reset (synchronous, active low) clears the control state and loads register defaults.
// ----------------------------------------------------------------------------
// block_padding_engine_top
// Byte stream padder and unpadder for PKCS7, ANSI X.923 and ISO 7816-4.
// ----------------------------------------------------------------------------
module block_padding_engine_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [1:0]                       i_cfg_index,
    input  logic [bpe_pkg::BS_W-1:0]         i_cfg_data,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] in_byte
    input  logic                             s_axis_tuser,  // [0] in_has_byte
    input  logic                             s_axis_tlast,
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [7:0] out_byte
    output logic [2:0]                       m_axis_tuser,  // [0] out_has_byte, [2:1] out_status
    output logic                             m_axis_tlast
);

    localparam int ADDR_W = bpe_pkg::ADDR_W;
    localparam int CNT_W  = bpe_pkg::CNT_W;
    localparam int BYTE_W = bpe_pkg::BYTE_W;
    localparam int STAT_W = bpe_pkg::STAT_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [bpe_pkg::MODE_W-1:0]    r_mode, n_mode;
    logic                          r_dir, n_dir;
    logic [bpe_pkg::BS_W-1:0]      r_bs, n_bs;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [ADDR_W-1:0]             r_head, n_head;
    logic [ADDR_W-1:0]             r_pos, n_pos;
    logic [ADDR_W-1:0]             r_idx, n_idx;
    logic [CNT_W-1:0]              r_p, n_p;
    logic [CNT_W-1:0]              r_keep, n_keep;
    logic [STAT_W-1:0]             r_st, n_st;

    logic                          r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]             r_out_byte, n_out_byte;
    logic                          r_out_has, n_out_has;
    logic                          r_out_last, n_out_last;
    logic [STAT_W-1:0]             r_out_status, n_out_status;

    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             rd_addr;
    logic [BYTE_W-1:0]             rd_data;
    logic [CNT_W-1:0]              eff_bs;
    logic                          out_free;
    logic                          in_xfer;

    assign eff_bs        = bpe_pkg::eff_block(r_bs);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Next-state logic
    always_comb begin
        logic [CNT_W-1:0]  pos1;
        logic [ADDR_W-1:0] pos_after;
        logic [CNT_W-1:0]  cnt_after;
        logic              fin;
        logic [BYTE_W-1:0] v;
        logic [BYTE_W-1:0] want;
        logic              done;
        logic [STAT_W-1:0] st_v;
        logic [CNT_W-1:0]  keep_v;

        n_state      = r_state;
        n_mode       = r_mode;
        n_dir        = r_dir;
        n_bs         = r_bs;
        n_count      = r_count;
        n_head       = r_head;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_p          = r_p;
        n_keep       = r_keep;
        n_st         = r_st;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_byte   = r_out_byte;
        n_out_has    = r_out_has;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        wr_en        = 1'b0;
        wr_addr      = r_head;
        pos1         = CNT_W'(r_pos) + CNT_W'(1);
        pos_after    = r_pos;
        cnt_after    = r_count;
        fin          = 1'b0;
        v            = rd_data;
        want         = '0;
        done         = 1'b0;
        st_v         = bpe_pkg::ST_OK;
        keep_v       = r_count;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (!r_dir) begin
                        // Pass the byte through and track the block position
                        if (s_axis_tuser) begin
                            n_out_valid  = 1'b1;
                            n_out_byte   = s_axis_tdata;
                            n_out_has    = 1'b1;
                            n_out_last   = 1'b0;
                            n_out_status = bpe_pkg::ST_OK;
                            pos_after    = (pos1 == eff_bs) ? '0 : pos1[ADDR_W-1:0];
                        end
                        n_pos = pos_after;
                        if (s_axis_tlast) begin
                            n_p     = eff_bs - CNT_W'(pos_after);
                            n_idx   = '0;
                            n_state = S_PAD;
                        end
                    end else begin
                        // Hold back the newest bytes; evict the oldest once full
                        if (s_axis_tuser) begin
                            wr_en = 1'b1;
                            if (r_count >= eff_bs) begin
                                n_out_valid  = 1'b1;
                                n_out_byte   = rd_data;
                                n_out_has    = 1'b1;
                                n_out_last   = 1'b0;
                                n_out_status = bpe_pkg::ST_OK;
                                wr_addr      = r_head;
                                n_head       = bpe_pkg::ring_add(r_head, ADDR_W'(1));
                            end else begin
                                wr_addr   = bpe_pkg::ring_add(r_head, r_count[ADDR_W-1:0]);
                                cnt_after = r_count + CNT_W'(1);
                            end
                        end
                        n_count = cnt_after;
                        if (s_axis_tlast) begin
                            if (cnt_after == '0) begin
                                n_st    = bpe_pkg::ST_SHORT;
                                n_state = S_LAST;
                            end else begin
                                n_idx   = ADDR_W'(cnt_after - CNT_W'(1));
                                n_state = S_SCAN;
                            end
                        end
                    end
                end
            end

            S_PAD: begin
                if (out_free) begin
                    fin = (CNT_W'(r_idx) == (r_p - CNT_W'(1)));
                    if (r_mode == bpe_pkg::MODE_X923) begin
                        v = fin ? BYTE_W'(r_p) : '0;
                    end else if (r_mode == bpe_pkg::MODE_ISO) begin
                        v = (r_idx == '0) ? bpe_pkg::ISO_MARK : '0;
                    end else begin
                        v = BYTE_W'(r_p);
                    end
                    n_out_valid  = 1'b1;
                    n_out_byte   = v;
                    n_out_has    = 1'b1;
                    n_out_last   = fin;
                    n_out_status = bpe_pkg::ST_OK;
                    if (fin) begin
                        n_count = '0;
                        n_head  = '0;
                        n_pos   = '0;
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + ADDR_W'(1);
                    end
                end
            end

            S_SCAN: begin
                // Walk the held window from the newest byte backwards
                if (r_mode == bpe_pkg::MODE_ISO) begin
                    if (v != '0) begin
                        done   = 1'b1;
                        if (v == bpe_pkg::ISO_MARK) begin
                            st_v   = bpe_pkg::ST_OK;
                            keep_v = CNT_W'(r_idx);
                        end else begin
                            st_v = bpe_pkg::ST_BAD_BYTES;
                        end
                    end else if (r_idx == '0) begin
                        done = 1'b1;
                        st_v = bpe_pkg::ST_BAD_BYTES;
                    end
                end else if (CNT_W'(r_idx) == (r_count - CNT_W'(1))) begin
                    // Newest byte gives the pad length
                    if ((v == '0) || (v > BYTE_W'(eff_bs))) begin
                        done = 1'b1;
                        st_v = bpe_pkg::ST_BAD_LEN;
                    end else if (v > BYTE_W'(r_count)) begin
                        done = 1'b1;
                        st_v = bpe_pkg::ST_SHORT;
                    end else if (v == BYTE_W'(1)) begin
                        done   = 1'b1;
                        keep_v = r_count - CNT_W'(1);
                    end
                    n_p = CNT_W'(v);
                end else begin
                    want = (r_mode == bpe_pkg::MODE_X923) ? '0 : BYTE_W'(r_p);
                    if (v != want) begin
                        done = 1'b1;
                        st_v = bpe_pkg::ST_BAD_BYTES;
                    end else if (CNT_W'(r_idx) == (r_count - r_p)) begin
                        done   = 1'b1;
                        keep_v = r_count - r_p;
                    end
                end
                if (done) begin
                    n_st   = st_v;
                    n_keep = keep_v;
                    n_idx  = '0;
                    n_state = (keep_v == '0) ? S_LAST : S_EMIT;
                end else begin
                    n_idx = r_idx - ADDR_W'(1);
                end
            end

            S_EMIT: begin
                // Flush the kept bytes oldest first
                if (out_free) begin
                    fin          = (CNT_W'(r_idx) == (r_keep - CNT_W'(1)));
                    n_out_valid  = 1'b1;
                    n_out_byte   = rd_data;
                    n_out_has    = 1'b1;
                    n_out_last   = fin;
                    n_out_status = fin ? r_st : bpe_pkg::ST_OK;
                    if (fin) begin
                        n_count = '0;
                        n_head  = '0;
                        n_pos   = '0;
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + ADDR_W'(1);
                    end
                end
            end

            S_LAST: begin
                // Final result without a byte
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = '0;
                    n_out_has    = 1'b0;
                    n_out_last   = 1'b1;
                    n_out_status = r_st;
                    n_count      = '0;
                    n_head       = '0;
                    n_pos        = '0;
                    n_idx        = '0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Writes to the mode, direction or block size register drop any message in progress
        if (i_cfg_wr_en) begin
            if ((i_cfg_index == bpe_pkg::REG_MODE) || (i_cfg_index == bpe_pkg::REG_DIR) ||
                (i_cfg_index == bpe_pkg::REG_BS)) begin
                case (i_cfg_index)
                    bpe_pkg::REG_MODE: n_mode = i_cfg_data[bpe_pkg::MODE_W-1:0];
                    bpe_pkg::REG_DIR:  n_dir  = i_cfg_data[0];
                    default:           n_bs   = i_cfg_data;
                endcase
                n_count = '0;
                n_head  = '0;
                n_pos   = '0;
                n_idx   = '0;
                n_state = S_IDLE;
            end
        end
    end

    // Read the entry the next cycle will look at
    assign rd_addr = bpe_pkg::ring_add(n_head, n_idx);

    bpe_hold_mem u_hold_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (s_axis_tdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= bpe_pkg::MODE_PKCS7;
            r_dir       <= 1'b0;
            r_bs        <= bpe_pkg::BS_W'(16);
            r_count     <= '0;
            r_head      <= '0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_dir       <= n_dir;
            r_bs        <= n_bs;
            r_count     <= n_count;
            r_head      <= n_head;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_p          <= n_p;
        r_keep       <= n_keep;
        r_st         <= n_st;
        r_out_byte   <= n_out_byte;
        r_out_has    <= n_out_has;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = {r_out_status, r_out_has};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // Hold count never exceeds the window
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(bpe_pkg::MAX_BLOCK))
        else $error("hold count beyond window");

    // A result without a byte is always the final one
    a_nobyte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has) |-> r_out_last)
        else $error("byteless result not last");

    // Nonzero status only on the final result
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != bpe_pkg::ST_OK)) |-> r_out_last)
        else $error("status on non-final result");

    // A pending final result means the sequencer is back to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_state == S_IDLE))
        else $error("final result while sequencer busy");

    // Pad burst index stays below the pad length
    a_pad_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |-> (CNT_W'(r_idx) < r_p))
        else $error("pad index out of range");
`endif

endmodule
